[rtl/b64e_pkg.sv]
// Package with the shared types, constants and the alphabet function of the base64 encoder.
package b64e_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [6:0] CHAR_PAD   = 7'h3D;
   localparam logic [6:0] CHAR_PLUS  = 7'h2B;
   localparam logic [6:0] CHAR_SLASH = 7'h2F;
   localparam logic [6:0] OFS_UPPER  = 7'd65;
   localparam logic [6:0] OFS_LOWER  = 7'd71;
   localparam logic [6:0] OFS_DIGIT  = 7'd124;

   localparam logic [1:0] PAIRS_NONE = 2'd0;
   localparam logic [1:0] PAIRS_ONE  = 2'd1;

   // One accepted byte turns into up to four characters.
   typedef struct packed {
      logic [3:0][6:0] chars;
      logic [1:0]      last_idx;
      logic            final_flag;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Maps a six-bit value onto the standard alphabet.
   function automatic logic [6:0] b64_char(input logic [5:0] six);
      logic [6:0] v;
      logic [6:0] code;
      v = {1'b0, six};
      priority if (six < 6'd26) begin
         code = v + OFS_UPPER;
      end else if (six < 6'd52) begin
         code = v + OFS_LOWER;
      end else if (six < 6'd62) begin
         code = v + OFS_DIGIT;
      end else if (six == 6'd62) begin
         code = CHAR_PLUS;
      end else begin
         code = CHAR_SLASH;
      end
      return code;
   endfunction

endpackage

[rtl/b64e_front.sv]
// Front end: accepts bytes, keeps the leftover bits and builds the character job for each byte.
module b64e_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   input  logic                      req_tlast,
   input  b64e_pkg::queue_status_type q_status,
   output logic                      push,
   output b64e_pkg::job_type         job
);

   logic [3:0] leftover_bits_ff, leftover_bits_in;
   logic [1:0] leftover_count_ff, leftover_count_in;

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      logic [3:0] nbits;
      logic [1:0] ncount;
      logic [1:0] k;
      job   = '0;
      nbits = '0;
      ncount = '0;
      k = '0;
      unique case (leftover_count_ff)
         b64e_pkg::PAIRS_NONE: begin
            job.chars[0] = b64e_pkg::b64_char(req_tdata[7:2]);
            nbits  = {2'b00, req_tdata[1:0]};
            ncount = 2'd1;
            k = 2'd0;
         end
         b64e_pkg::PAIRS_ONE: begin
            job.chars[0] = b64e_pkg::b64_char({leftover_bits_ff[1:0], req_tdata[7:4]});
            nbits  = req_tdata[3:0];
            ncount = 2'd2;
            k = 2'd0;
         end
         default: begin
            // Two pending pairs (a count of three acts the same): the group closes.
            job.chars[0] = b64e_pkg::b64_char({leftover_bits_ff, req_tdata[7:6]});
            job.chars[1] = b64e_pkg::b64_char(req_tdata[5:0]);
            nbits  = '0;
            ncount = 2'd0;
            k = 2'd1;
         end
      endcase

      if (req_tlast) begin
         if (ncount == 2'd1) begin
            job.chars[1] = b64e_pkg::b64_char({nbits[1:0], 4'b0000});
            job.chars[2] = b64e_pkg::CHAR_PAD;
            job.chars[3] = b64e_pkg::CHAR_PAD;
            k = 2'd3;
         end else if (ncount == 2'd2) begin
            job.chars[1] = b64e_pkg::b64_char({nbits, 2'b00});
            job.chars[2] = b64e_pkg::CHAR_PAD;
            k = 2'd2;
         end
         nbits  = '0;
         ncount = '0;
      end
      job.last_idx   = k;
      job.final_flag = req_tlast;
      leftover_bits_in  = push ? nbits  : leftover_bits_ff;
      leftover_count_in = push ? ncount : leftover_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leftover_bits_ff  <= '0;
         leftover_count_ff <= '0;
      end else begin
         leftover_bits_ff  <= leftover_bits_in;
         leftover_count_ff <= leftover_count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      leftover_count_ff != 2'd3)
      else $error("leftover count reached an impossible value");

   assert property (@(posedge clock) disable iff (reset)
      (push && req_tlast) |=> (leftover_count_ff == 2'd0 && leftover_bits_ff == 4'd0))
      else $error("state not cleared after the last byte of a message");

endmodule

[rtl/b64e_queue.sv]
// Short job queue between the front end and the character back end.
module b64e_queue #(
   parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  b64e_pkg::job_type          push_job,
   input  logic                       pop,
   output b64e_pkg::job_type          head_job,
   output b64e_pkg::queue_status_type status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   b64e_pkg::job_type slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign head_job     = slots_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("job queue popped while empty");

   assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("job queue pushed while full");

endmodule

[rtl/b64e_back.sv]
// Back end: walks head job characters into output register, one per cycle unless stalled.
module b64e_back (
   input  logic                       clock,
   input  logic                       reset,
   input  b64e_pkg::job_type          head_job,
   input  b64e_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic                       rsp_tlast
);

   logic [1:0] char_idx_ff, char_idx_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       end_ff, end_in;
   logic       load;
   logic       at_last;

   assign load    = !q_status.empty && (!valid_ff || rsp_tready);
   assign at_last = (char_idx_ff == head_job.last_idx);
   assign pop     = load && at_last;

   always_comb begin
      char_idx_in = char_idx_ff;
      valid_in    = valid_ff;
      char_in     = char_ff;
      end_in      = end_ff;
      if (load) begin
         valid_in    = 1'b1;
         char_in     = head_job.chars[char_idx_ff];
         end_in      = at_last && head_job.final_flag;
         char_idx_in = at_last ? 2'd0 : char_idx_ff + 2'd1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      end_ff  <= end_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_idx_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         char_idx_ff <= char_idx_in;
         valid_ff    <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, char_ff};
   assign rsp_tlast  = end_ff;

   assert property (@(posedge clock) disable iff (reset)
      (char_idx_ff <= head_job.last_idx) || q_status.empty)
      else $error("character index ran past the end of its job");

   assert property (@(posedge clock) disable iff (reset)
      (load && !at_last) |=> (char_idx_ff != 2'd0))
      else $error("character index lost its place inside a job");

endmodule

[rtl/base64_stream_encoder_top.sv]
// Top level of the streaming base64 encoder: front end, job queue and character back end.
//
//  Channel | Direction | Handshake             | Payload
//  req     | in        | req_tvalid/req_tready | tdata = data_byte, tlast = final_byte
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata = char_code, tlast = end_of_text
//
// A byte request is taken in any cycle in which the job queue has room; the front end
// turns it into its one to four characters in that same cycle and queues them as a job.
// The back end sends one character per cycle from the head job while rsp_tready allows,
// so a byte gives one or two characters, and up to four on the last byte of a message;
// that serializer, not the byte intake, limits the throughput on long messages.
// Reset clears the leftover bits, the queue pointers and count, and the output valid flag.
// A stall on rsp_tready holds the output register; the queue then fills and req_tready
// drops only once QUEUE_DEPTH jobs wait behind it.
module base64_stream_encoder_top #(
   parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // final_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] char_code, [7] zero fill
   output logic       rsp_tlast    // end_of_text
);

   b64e_pkg::job_type          new_job;
   b64e_pkg::job_type          head_job;
   b64e_pkg::queue_status_type q_status;
   logic                       push;
   logic                       pop;

   // The front end classifies each byte against the pending bits and builds its job.
   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .job        (new_job)
   );

   // The queue decouples byte intake from character output.
   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (new_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // The back end emits the characters of the head job one at a time.
   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[tb/testbench.sv]
// Self-checking testbench for the streaming base64 encoder: directed table, then random messages.
module testbench;

   // The run is stopped here even if the encoder hangs. This leaves a wide margin
   // over the slowest correct run.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 500;
   // The last stretch of the random part runs with idling off, so no new gaps or stalls start.
   localparam int CALM_ITEMS   = 60;
   localparam int DRAIN_CYCLES = 20;
   localparam int N_DIRECTED   = 20;

   // One character on the result channel, as the encoder should emit it.
   typedef struct packed {
      logic [6:0] char_code;
      logic       end_of_text;
   } encoded_char_type;

   // One row of the directed table. A row with n_chars of zero is checked
   // against the predictor. Otherwise the text in chars is the expected output
   // of that byte, first character in the highest byte, right aligned.
   typedef struct packed {
      logic [7:0]  value;
      logic        is_last;
      logic [2:0]  n_chars;
      logic [31:0] chars;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [0:N_DIRECTED-1] = '{
      // A single zero byte and a single all-ones byte: flush plus two pads.
      '{8'h00, 1'b1, 3'd4, "AA=="},
      '{8'hFF, 1'b1, 3'd4, "/w=="},
      // Two zero bytes: flush plus one pad.
      '{8'h00, 1'b0, 3'd1, "A"},
      '{8'h00, 1'b1, 3'd3, "AA="},
      // The final byte completes a group, so no flush and no padding follow.
      '{8'h4D, 1'b0, 3'd1, "T"},
      '{8'h61, 1'b0, 3'd1, "W"},
      '{8'h6E, 1'b1, 3'd2, "Fu"},
      '{8'hFF, 1'b0, 3'd1, "/"},
      '{8'hFF, 1'b0, 3'd1, "/"},
      '{8'hFF, 1'b1, 3'd2, "//"},
      // Every sextet is 62, the plus sign.
      '{8'hFB, 1'b0, 3'd1, "+"},
      '{8'hEF, 1'b0, 3'd1, "+"},
      '{8'hBE, 1'b1, 3'd2, "++"},
      // Upper case, lower case and a digit, with one pad.
      '{8'h66, 1'b0, 3'd1, "Z"},
      '{8'h6F, 1'b1, 3'd3, "m8="},
      // A longer message checked against the predictor.
      '{8'h80, 1'b0, 3'd0, 32'd0},
      '{8'h01, 1'b0, 3'd0, 32'd0},
      '{8'h7F, 1'b0, 3'd0, 32'd0},
      '{8'hA5, 1'b0, 3'd0, 32'd0},
      '{8'h5A, 1'b1, 3'd0, 32'd0}
   };

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] data_byte
   logic       req_tlast  = 1'b0;    // final_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [6:0] char_code, [7] zero fill
   logic       rsp_tlast;            // end_of_text

   base64_stream_encoder_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Characters still owed by the encoder, oldest first.
   encoded_char_type expected_chars [$];
   // Typed answers for requests in flight, in the order they were driven.
   directed_row_type typed_answers [$];
   // Characters that the predictor produced for the latest byte.
   encoded_char_type step_out [$];

   // Appends at the tail of the queues above.
   function automatic void add_step_char(input encoded_char_type c);
      step_out.insert(step_out.size(), c);
   endfunction

   function automatic void add_expected_char(input encoded_char_type c);
      expected_chars.insert(expected_chars.size(), c);
   endfunction

   function automatic void add_typed_answer(input directed_row_type row);
      typed_answers.insert(typed_answers.size(), row);
   endfunction

   int mismatch_count = 0;
   int cycle_count    = 0;
   // Chance in percent that a stall burst starts in a given cycle, or that a gap comes before a byte request.
   int idle_pct       = 0;
   int stall_left     = 0;

   // Predictor state: the bits not yet emitted, their count in pairs, and the
   // byte position inside the current three-byte group.
   logic [3:0] pend_bits  = 4'd0;
   logic [1:0] pend_pairs = 2'd0;
   logic [1:0] group_pos  = 2'd0;

   string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   function automatic logic [6:0] alphabet_code(input logic [5:0] six);
      logic [7:0] ch;
      ch = alphabet[six];
      return ch[6:0];
   endfunction

   // Works out the characters that one byte causes and advances the state.
   function automatic void encode_byte(input logic [7:0] value, input logic is_last);
      logic [11:0] acc;
      logic [1:0]  pairs;
      acc   = {pend_bits, value};
      // A pair count of three cannot be reached from reset; it acts as two.
      pairs = (pend_pairs == 2'd3) ? 2'd2 : pend_pairs;
      step_out.delete();
      case (pairs)
         2'd0: begin
            add_step_char({alphabet_code(acc[7:2]), 1'b0});
            pend_bits  = {2'b00, acc[1:0]};
            pend_pairs = 2'd1;
            group_pos  = 2'd1;
         end
         2'd1: begin
            add_step_char({alphabet_code(acc[9:4]), 1'b0});
            pend_bits  = acc[3:0];
            pend_pairs = 2'd2;
            group_pos  = 2'd2;
         end
         default: begin
            add_step_char({alphabet_code(acc[11:6]), 1'b0});
            add_step_char({alphabet_code(acc[5:0]), 1'b0});
            pend_bits  = 4'd0;
            pend_pairs = 2'd0;
            group_pos  = 2'd0;
         end
      endcase
      if (is_last) begin
         // Flush the pending bits padded with zeros, then fill up with pads.
         if (pend_pairs == 2'd1) begin
            add_step_char({alphabet_code({pend_bits[1:0], 4'b0000}), 1'b0});
            add_step_char({b64e_pkg::CHAR_PAD, 1'b0});
            add_step_char({b64e_pkg::CHAR_PAD, 1'b0});
         end else if (pend_pairs == 2'd2) begin
            add_step_char({alphabet_code({pend_bits, 2'b00}), 1'b0});
            add_step_char({b64e_pkg::CHAR_PAD, 1'b0});
         end
         step_out[step_out.size() - 1].end_of_text = 1'b1;
         pend_bits  = 4'd0;
         pend_pairs = 2'd0;
         group_pos  = 2'd0;
      end
   endfunction

   // Watches both channels at every rising edge. A request is predicted before
   // the result channel is checked, so both happen in one ordered process.
   always @(posedge clock) begin
      directed_row_type answer;
      encoded_char_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            answer = typed_answers.pop_front();
            encode_byte(req_tdata, req_tlast);
            if (answer.n_chars == 3'd0) begin
               foreach (step_out[i]) add_expected_char(step_out[i]);
            end else begin
               for (int i = 0; i < answer.n_chars; i++) begin
                  add_expected_char(
                     {answer.chars[8 * (answer.n_chars - 1 - i) +: 7],
                      req_tlast && (i == answer.n_chars - 1)});
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected character: expected none, actual %h (end_of_text %b)",
                        $time, rsp_tdata[6:0], rsp_tlast);
               mismatch_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata[6:0] !== want.char_code) begin
                  $display("%0t: char_code: expected %h, actual %h",
                           $time, want.char_code, rsp_tdata[6:0]);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.end_of_text) begin
                  $display("%0t: end_of_text: expected %b, actual %b",
                           $time, want.end_of_text, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // The receiver drops rsp_tready in random stall bursts.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         stall_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Drives one byte request and returns at the edge where it is taken. Called
   // at a rising edge; an idle gap may come first.
   task automatic send_byte(input logic [7:0] value, input logic is_last);
      int gap;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Lowers valid and waits, at falling edges where all updates have settled,
   // until the encoder owes no more characters.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (expected_chars.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      int         bytes_sent;
      int         msg_len;
      logic [7:0] value;
      bit         drained_once;
      bytes_sent   = 0;
      drained_once = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with moderate idling on both sides.
      idle_pct = 20;
      for (int r = 0; r < N_DIRECTED; r++) begin
         add_typed_answer(DIRECTED_ROWS[r]);
         send_byte(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].is_last);
      end

      // Random part: well-formed messages of random length and content. The
      // idling level changes per message, so some stretches have none.
      while (bytes_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) msg_len = $urandom_range(1, 3);
         else msg_len = $urandom_range(1, 12);
         if (bytes_sent >= RANDOM_ITEMS - CALM_ITEMS) begin
            idle_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: idle_pct = 0;
               1: idle_pct = 15;
               default: idle_pct = 40;
            endcase
         end
         for (int j = 0; j < msg_len; j++) begin
            case ($urandom_range(0, 9))
               0: value = 8'h00;
               1: value = 8'hFF;
               default: value = 8'($urandom_range(0, 255));
            endcase
            add_typed_answer('0);
            send_byte(value, j == msg_len - 1);
            bytes_sent++;
         end
         // Once, halfway through, the sender holds off until all is drained.
         if (!drained_once && bytes_sent >= RANDOM_ITEMS / 2) begin
            drained_once = 1'b1;
            wait_drained();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
